@@ hdl/smcd_pkg.sv @@
// Shared types, character codes and drive constants for the serial motor command decoder.
`default_nettype none
package smcd_pkg;

   localparam int MAX_DIGITS = 5;
   localparam int COUNT_W    = 3;
   localparam int NUM_W      = 17;
   localparam int SPEED_W    = NUM_W + 1;

   typedef logic [7:0]                rx_byte_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [NUM_W-1:0]          number_type;
   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic [7:0]                duty_type;

   localparam speed_type SPEED_BRAKE   = speed_type'(11);
   localparam speed_type SPEED_FWD_MAX = speed_type'(10);
   localparam speed_type SPEED_ZERO    = speed_type'(0);
   localparam duty_type  DUTY_FULL     = 8'd255;

   // ASCII codes
   localparam rx_byte_type ASCII_LF   = 8'h0A;
   localparam rx_byte_type ASCII_CR   = 8'h0D;
   localparam rx_byte_type ASCII_ZERO = 8'h30;
   localparam rx_byte_type ASCII_NINE = 8'h39;
   localparam rx_byte_type ASCII_UP_K = 8'h4B;
   localparam rx_byte_type ASCII_UP_M = 8'h4D;
   localparam rx_byte_type ASCII_B    = 8'h62;
   localparam rx_byte_type ASCII_D    = 8'h64;
   localparam rx_byte_type ASCII_E    = 8'h65;
   localparam rx_byte_type ASCII_F    = 8'h66;
   localparam rx_byte_type ASCII_G    = 8'h67;
   localparam rx_byte_type ASCII_H    = 8'h68;
   localparam rx_byte_type ASCII_I    = 8'h69;
   localparam rx_byte_type ASCII_L    = 8'h6C;
   localparam rx_byte_type ASCII_M    = 8'h6D;
   localparam rx_byte_type ASCII_N    = 8'h6E;
   localparam rx_byte_type ASCII_O    = 8'h6F;
   localparam rx_byte_type ASCII_P    = 8'h70;
   localparam rx_byte_type ASCII_Q    = 8'h71;
   localparam rx_byte_type ASCII_R    = 8'h72;
   localparam rx_byte_type ASCII_S    = 8'h73;

   typedef enum logic [10:0] {
      PH_WAIT   = 11'b00000000001,
      PH_M      = 11'b00000000010,
      PH_K      = 11'b00000000100,
      PH_PING_I = 11'b00000001000,
      PH_PING_N = 11'b00000010000,
      PH_PING_G = 11'b00000100000,
      PH_HELP_E = 11'b00001000000,
      PH_HELP_L = 11'b00010000000,
      PH_HELP_P = 11'b00100000000,
      PH_NUMBER = 11'b01000000000,
      PH_FLUSH  = 11'b10000000000
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_LEFT  = 3'd1,
      CMD_RIGHT = 3'd2,
      CMD_AUX   = 3'd3,
      CMD_FWD   = 3'd4,
      CMD_BACK  = 3'd5,
      CMD_TURNR = 3'd6,
      CMD_TURNL = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      REPLY_NONE  = 2'd0,
      REPLY_PONG  = 2'd1,
      REPLY_IDENT = 2'd2,
      REPLY_HELP  = 2'd3
   } reply_type;

   typedef struct packed {
      speed_type left_speed;
      speed_type right_speed;
      reply_type reply;
      logic      stream_on;
      logic      done;
   } parse_result_type;

   // duty for speed magnitudes below ten: mag*255/10
   function automatic duty_type duty_small(input logic [3:0] mag);
      duty_type d;
      case (mag)
         4'd0:    d = 8'd0;
         4'd1:    d = 8'd25;
         4'd2:    d = 8'd51;
         4'd3:    d = 8'd76;
         4'd4:    d = 8'd102;
         4'd5:    d = 8'd127;
         4'd6:    d = 8'd153;
         4'd7:    d = 8'd178;
         4'd8:    d = 8'd204;
         4'd9:    d = 8'd229;
         default: d = DUTY_FULL;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

@@ hdl/serial_motor_command_decoder_top.sv @@
// Pipeline: an accepted request is captured in the input register, and its parser
// and drive result is captured in the result register when that register advances.
// Throughput: one request per cycle; the input register advances whenever the
// result register is empty or being taken, so the only limit is rsp_stall.
// Reset (synchronous): both pipeline valids clear, parser returns to waiting
// for a command start, both motors brake, streaming off.
`default_nettype none
module serial_motor_command_decoder_top (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire smcd_pkg::rx_byte_type req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output smcd_pkg::duty_type         rsp_left_duty,
   output logic                       rsp_left_pin_a,
   output logic                       rsp_left_pin_b,
   output smcd_pkg::duty_type         rsp_right_duty,
   output logic                       rsp_right_pin_a,
   output logic                       rsp_right_pin_b,
   output logic [1:0]                 rsp_reply_code,
   output logic                       rsp_stream_on,
   output logic                       rsp_command_done
);
   import smcd_pkg::*;

   logic             in_valid_ff;
   rx_byte_type      in_byte_ff;
   logic             advance;
   logic             step;
   parse_result_type result;
   duty_type         left_duty, right_duty;
   logic             left_a, left_b, right_a, right_b;

   logic             out_valid_ff;
   duty_type         left_duty_ff, right_duty_ff;
   logic             left_a_ff, left_b_ff, right_a_ff, right_b_ff;
   reply_type        reply_ff;
   logic             stream_ff, done_ff;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   smcd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .enable  (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   smcd_drive u_left_drive (
      .speed (result.left_speed),
      .duty  (left_duty),
      .pin_a (left_a),
      .pin_b (left_b)
   );

   smcd_drive u_right_drive (
      .speed (result.right_speed),
      .duty  (right_duty),
      .pin_a (right_a),
      .pin_b (right_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // hold the result while stalled
   always_ff @(posedge clock) begin
      if (step) begin
         left_duty_ff  <= left_duty;
         left_a_ff     <= left_a;
         left_b_ff     <= left_b;
         right_duty_ff <= right_duty;
         right_a_ff    <= right_a;
         right_b_ff    <= right_b;
         reply_ff      <= result.reply;
         stream_ff     <= result.stream_on;
         done_ff       <= result.done;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_left_duty    = left_duty_ff;
   assign rsp_left_pin_a   = left_a_ff;
   assign rsp_left_pin_b   = left_b_ff;
   assign rsp_right_duty   = right_duty_ff;
   assign rsp_right_pin_a  = right_a_ff;
   assign rsp_right_pin_b  = right_b_ff;
   assign rsp_reply_code   = reply_ff;
   assign rsp_stream_on    = stream_ff;
   assign rsp_command_done = done_ff;

endmodule
`default_nettype wire

@@ hdl/smcd_parser.sv @@
// Command parser: phase state machine, number collection and speed/stream state.
`default_nettype none
module smcd_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      enable,
   input  wire smcd_pkg::rx_byte_type     rx_byte,
   output smcd_pkg::parse_result_type     result
);
   import smcd_pkg::*;

   phase_type  phase_ff,  phase_in;
   cmd_type    cmd_ff,    cmd_in;
   count_type  count_ff,  count_in;
   number_type num_ff,    num_in;
   speed_type  left_ff,   left_in;
   speed_type  right_ff,  right_in;
   logic       stream_ff, stream_in;
   reply_type  reply;
   logic       done;

   always_comb begin
      logic       line_end;
      logic       apply_en;
      number_type apply_val;
      number_type num_step;
      count_type  count_step;

      line_end   = rx_byte inside {ASCII_LF, ASCII_CR};
      apply_en   = 1'b0;
      apply_val  = num_ff;
      num_step   = (num_ff << 3) + (num_ff << 1) + NUM_W'(rx_byte - ASCII_ZERO);
      count_step = count_ff + count_type'(1);

      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      num_in    = num_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      stream_in = stream_ff;
      reply     = REPLY_NONE;
      done      = 1'b0;

      case (phase_ff)
         PH_WAIT: begin
            if (!line_end) begin
               case (rx_byte)
                  ASCII_UP_M: phase_in = PH_M;
                  ASCII_UP_K: phase_in = PH_K;
                  ASCII_P:    phase_in = PH_PING_I;
                  ASCII_H:    phase_in = PH_HELP_E;
                  default: begin
                     stream_in = 1'b0;
                     phase_in  = PH_FLUSH;
                  end
               endcase
            end
         end
         PH_M: begin
            phase_in = PH_FLUSH;
            case (rx_byte)
               ASCII_N: begin
                  reply = REPLY_IDENT;
                  done  = 1'b1;
               end
               ASCII_S: begin
                  stream_in = 1'b1;
                  done      = 1'b1;
               end
               ASCII_F, ASCII_M: begin
                  stream_in = 1'b0;
                  done      = 1'b1;
               end
               ASCII_E: begin
                  cmd_in = CMD_LEFT;  phase_in = PH_NUMBER;
               end
               ASCII_D: begin
                  cmd_in = CMD_RIGHT; phase_in = PH_NUMBER;
               end
               ASCII_O, ASCII_P, ASCII_Q, ASCII_R, ASCII_UP_M: begin
                  cmd_in = CMD_AUX;   phase_in = PH_NUMBER;
               end
               default: begin
                  stream_in = 1'b0;
                  phase_in  = line_end ? PH_WAIT : PH_FLUSH;
               end
            endcase
            if (phase_in == PH_NUMBER) begin
               count_in = '0;
               num_in   = '0;
            end
         end
         PH_K: begin
            phase_in = PH_FLUSH;
            case (rx_byte)
               ASCII_S: begin
                  left_in  = SPEED_BRAKE;
                  right_in = SPEED_BRAKE;
                  done     = 1'b1;
               end
               ASCII_F: begin
                  cmd_in = CMD_FWD;   phase_in = PH_NUMBER;
               end
               ASCII_B: begin
                  cmd_in = CMD_BACK;  phase_in = PH_NUMBER;
               end
               ASCII_R: begin
                  cmd_in = CMD_TURNR; phase_in = PH_NUMBER;
               end
               ASCII_L: begin
                  cmd_in = CMD_TURNL; phase_in = PH_NUMBER;
               end
               default: begin
                  stream_in = 1'b0;
                  phase_in  = line_end ? PH_WAIT : PH_FLUSH;
               end
            endcase
            if (phase_in == PH_NUMBER) begin
               count_in = '0;
               num_in   = '0;
            end
         end
         PH_PING_I: phase_in = (rx_byte == ASCII_I) ? PH_PING_N :
                               (line_end ? PH_WAIT : PH_FLUSH);
         PH_PING_N: phase_in = (rx_byte == ASCII_N) ? PH_PING_G :
                               (line_end ? PH_WAIT : PH_FLUSH);
         PH_PING_G: begin
            if (rx_byte == ASCII_G) begin
               reply    = REPLY_PONG;
               done     = 1'b1;
               phase_in = PH_FLUSH;
            end else begin
               phase_in = line_end ? PH_WAIT : PH_FLUSH;
            end
         end
         PH_HELP_E: phase_in = (rx_byte == ASCII_E) ? PH_HELP_L :
                               (line_end ? PH_WAIT : PH_FLUSH);
         PH_HELP_L: phase_in = (rx_byte == ASCII_L) ? PH_HELP_P :
                               (line_end ? PH_WAIT : PH_FLUSH);
         PH_HELP_P: begin
            if (rx_byte == ASCII_P) begin
               reply    = REPLY_HELP;
               done     = 1'b1;
               phase_in = PH_FLUSH;
            end else begin
               phase_in = line_end ? PH_WAIT : PH_FLUSH;
            end
         end
         PH_NUMBER: begin
            if (rx_byte inside {[ASCII_ZERO:ASCII_NINE]}) begin
               num_in   = num_step;
               count_in = count_step;
               if (count_step >= COUNT_W'(MAX_DIGITS)) begin
                  apply_en  = 1'b1;
                  apply_val = num_step;
                  phase_in  = PH_FLUSH;
               end
            end else if (count_ff != '0 && line_end) begin
               apply_en  = 1'b1;
               apply_val = num_ff;
               phase_in  = PH_WAIT;
            end
         end
         PH_FLUSH: begin
            if (line_end) begin
               phase_in = PH_WAIT;
            end
         end
         default: phase_in = PH_WAIT;
      endcase

      if (apply_en) begin
         done = 1'b1;
         case (cmd_ff)
            CMD_LEFT:  left_in  = speed_type'({1'b0, apply_val});
            CMD_RIGHT: right_in = speed_type'({1'b0, apply_val});
            CMD_FWD: begin
               left_in  = speed_type'({1'b0, apply_val});
               right_in = speed_type'({1'b0, apply_val});
            end
            CMD_BACK: begin
               left_in  = -speed_type'({1'b0, apply_val});
               right_in = -speed_type'({1'b0, apply_val});
            end
            CMD_TURNR: begin
               left_in  = SPEED_ZERO;
               right_in = speed_type'({1'b0, apply_val});
            end
            CMD_TURNL: begin
               left_in  = speed_type'({1'b0, apply_val});
               right_in = SPEED_ZERO;
            end
            default: stream_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         cmd_ff    <= CMD_NONE;
         count_ff  <= '0;
         num_ff    <= '0;
         left_ff   <= SPEED_BRAKE;
         right_ff  <= SPEED_BRAKE;
         stream_ff <= 1'b0;
      end else if (enable) begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         count_ff  <= count_in;
         num_ff    <= num_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         stream_ff <= stream_in;
      end
   end

   assign result.left_speed  = left_in;
   assign result.right_speed = right_in;
   assign result.reply       = reply;
   assign result.stream_on   = stream_in;
   assign result.done        = done;

endmodule
`default_nettype wire

@@ hdl/smcd_drive.sv @@
// Bridge drive: PWM compare value and bridge pin levels from a signed motor speed.
`default_nettype none
module smcd_drive (
   input  wire smcd_pkg::speed_type speed,
   output smcd_pkg::duty_type       duty,
   output logic                     pin_a,
   output logic                     pin_b
);
   import smcd_pkg::*;

   speed_type mag;

   always_comb begin
      mag = (speed < SPEED_ZERO) ? -speed : speed;
      // ten and above saturates at full scale
      if (mag >= SPEED_FWD_MAX) begin
         duty = DUTY_FULL;
      end else begin
         duty = duty_small(mag[3:0]);
      end

      if (speed == SPEED_BRAKE) begin
         pin_a = 1'b1;
         pin_b = 1'b1;
      end else if (speed >= SPEED_ZERO && speed <= SPEED_FWD_MAX) begin
         pin_a = 1'b1;
         pin_b = 1'b0;
      end else begin
         pin_a = 1'b0;
         pin_b = 1'b1;
      end
   end

endmodule
`default_nettype wire
